>>> design/msp_pkg.sv
// ----------------------------------------------------------------------------
// msp_pkg: shared types and constants of the max score path block
// Controller states, datapath operations, address selects and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package msp_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_JUMP_PENALTY = 2'd0;
  localparam logic [1:0] CFG_ROWS_IN_USE  = 2'd1;
  localparam logic [1:0] CFG_COLS_IN_USE  = 2'd2;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [15:0] JUMP_PENALTY_RST = 16'd256;
  localparam logic [5:0]  ROWS_RST         = 6'd32;
  localparam logic [5:0]  COLS_RST         = 6'd32;

  // Q8.8 constants: starting floor of every interior cell and best value seed.
  localparam int START_FLOOR = -9 * 256;
  localparam int BEST_INIT   = -100 * 256;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD_WR,
    S_COPY_INIT,
    S_COPY_RD,
    S_COPY_WR,
    S_SCORE_INIT,
    S_CELL_INIT,
    S_I_RD,
    S_I_USE,
    S_J_INIT,
    S_J_RD,
    S_J_USE,
    S_SIM_RD,
    S_CELL_WR,
    S_PATH_INIT,
    S_PATH_CHK,
    S_DN_RD,
    S_DN_USE,
    S_RT_RD,
    S_RT_USE,
    S_DG_RD,
    S_DG_USE,
    S_EMIT,
    S_EMIT_END
  } ctrl_state_e;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD_TAKE,
    OP_LOAD_WRITE,
    OP_COPY_INIT,
    OP_COPY_WRITE,
    OP_SCORE_INIT,
    OP_CELL_INIT,
    OP_ISCAN_USE,
    OP_JSCAN_INIT,
    OP_JSCAN_USE,
    OP_CELL_WRITE,
    OP_PATH_INIT,
    OP_TAKE_DN,
    OP_TAKE_RT,
    OP_TAKE_DG,
    OP_EMIT,
    OP_EMIT_END
  } dp_op_e;

  typedef enum logic [2:0] {
    A_LOAD,
    A_CELL,
    A_ISCAN,
    A_JSCAN,
    A_DOWN,
    A_RIGHT,
    A_DIAG
  } addr_sel_e;

  typedef struct packed {
    dp_op_e    op;
    addr_sel_e addr_sel;
  } msp_cmd_t;

  typedef struct packed {
    logic last;
    logic copy_last;
    logic i_done;
    logic j_done;
    logic cell_last;
    logic at_edge;
    logic out_free;
  } msp_stat_t;

endpackage

>>> design/msp_ram.sv
// ----------------------------------------------------------------------------
// msp_ram: generic single-port-write, single-port-read RAM
// One write and one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
module msp_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> design/msp_ctrl.sv
// ----------------------------------------------------------------------------
// msp_ctrl: sequencer of the max score path block
// Steps through loading, edge copy, interior scoring and path output,
// issuing one datapath operation and one memory address select per cycle.
// ----------------------------------------------------------------------------
module msp_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               s_axis_tvalid_i,
  output logic               s_axis_tready_o,
  input  msp_pkg::msp_stat_t stat_i,
  output msp_pkg::msp_cmd_t  cmd_o
);
  import msp_pkg::*;

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:       if (s_axis_tvalid_i) state_d = S_LOAD_WR;
      S_LOAD_WR:    state_d = stat_i.last ? S_COPY_INIT : S_IDLE;
      S_COPY_INIT:  state_d = S_COPY_RD;
      S_COPY_RD:    state_d = S_COPY_WR;
      S_COPY_WR:    state_d = stat_i.copy_last ? S_SCORE_INIT : S_COPY_RD;
      S_SCORE_INIT: state_d = S_CELL_INIT;
      S_CELL_INIT:  state_d = S_I_RD;
      S_I_RD:       state_d = stat_i.i_done ? S_J_INIT : S_I_USE;
      S_I_USE:      state_d = S_I_RD;
      S_J_INIT:     state_d = S_J_RD;
      S_J_RD:       state_d = stat_i.j_done ? S_SIM_RD : S_J_USE;
      S_J_USE:      state_d = S_J_RD;
      S_SIM_RD:     state_d = S_CELL_WR;
      S_CELL_WR:    state_d = stat_i.cell_last ? S_PATH_INIT : S_CELL_INIT;
      S_PATH_INIT:  state_d = S_PATH_CHK;
      S_PATH_CHK:   state_d = stat_i.at_edge ? S_EMIT_END : S_DN_RD;
      S_DN_RD:      state_d = S_DN_USE;
      S_DN_USE:     state_d = S_RT_RD;
      S_RT_RD:      state_d = S_RT_USE;
      S_RT_USE:     state_d = S_DG_RD;
      S_DG_RD:      state_d = S_DG_USE;
      S_DG_USE:     state_d = S_EMIT;
      S_EMIT:       if (stat_i.out_free) state_d = S_PATH_CHK;
      S_EMIT_END:   if (stat_i.out_free) state_d = S_IDLE;
      default:      state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.op        = OP_NONE;
    cmd_o.addr_sel  = A_CELL;
    s_axis_tready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        cmd_o.addr_sel  = A_LOAD;
        if (s_axis_tvalid_i) cmd_o.op = OP_LOAD_TAKE;
      end
      S_LOAD_WR: begin
        cmd_o.addr_sel = A_LOAD;
        cmd_o.op       = OP_LOAD_WRITE;
      end
      S_COPY_INIT:  cmd_o.op = OP_COPY_INIT;
      S_COPY_RD:    cmd_o.addr_sel = A_CELL;
      S_COPY_WR:    cmd_o.op = OP_COPY_WRITE;
      S_SCORE_INIT: cmd_o.op = OP_SCORE_INIT;
      S_CELL_INIT:  cmd_o.op = OP_CELL_INIT;
      S_I_RD:       cmd_o.addr_sel = A_ISCAN;
      S_I_USE:      cmd_o.op = OP_ISCAN_USE;
      S_J_INIT:     cmd_o.op = OP_JSCAN_INIT;
      S_J_RD:       cmd_o.addr_sel = A_JSCAN;
      S_J_USE:      cmd_o.op = OP_JSCAN_USE;
      S_SIM_RD:     cmd_o.addr_sel = A_CELL;
      S_CELL_WR:    cmd_o.op = OP_CELL_WRITE;
      S_PATH_INIT:  cmd_o.op = OP_PATH_INIT;
      S_PATH_CHK:   cmd_o.op = OP_NONE;
      S_DN_RD:      cmd_o.addr_sel = A_DOWN;
      S_DN_USE:     cmd_o.op = OP_TAKE_DN;
      S_RT_RD:      cmd_o.addr_sel = A_RIGHT;
      S_RT_USE:     cmd_o.op = OP_TAKE_RT;
      S_DG_RD:      cmd_o.addr_sel = A_DIAG;
      S_DG_USE:     cmd_o.op = OP_TAKE_DG;
      S_EMIT:       if (stat_i.out_free) cmd_o.op = OP_EMIT;
      S_EMIT_END:   if (stat_i.out_free) cmd_o.op = OP_EMIT_END;
      default:      cmd_o.op = OP_NONE;
    endcase
  end

  // A final element always starts a scoring pass, so no element follows it.
  a_last_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD_WR && stat_i.last) |=> !s_axis_tready_o)
    else $error("input taken right after a final element");

  a_emit_only_off_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PATH_CHK && stat_i.at_edge) |=> state_q == S_EMIT_END)
    else $error("path continued past an edge");

  a_scan_reads_cell: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SIM_RD) |=> (state_q == S_CELL_WR && cmd_o.op == OP_CELL_WRITE))
    else $error("cell write did not follow its similarity read");

endmodule

>>> design/msp_dp.sv
// ----------------------------------------------------------------------------
// msp_dp: datapath of the max score path block
// Configuration registers, load index, cell and scan counters, running
// maximum with jump penalty, best cell tracking and the output register.
// ----------------------------------------------------------------------------
module msp_dp #(
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned MAX_COLS   = 32,
  parameter int unsigned SCORE_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  msp_pkg::msp_cmd_t                       cmd_i,
  output msp_pkg::msp_stat_t                      stat_o,
  input  logic [15:0]                             in_sim_i,
  input  logic                                    in_acc_i,
  input  logic                                    in_last_i,
  input  logic                                    cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]           cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]          cfg_data_i,
  output logic [$clog2(MAX_ROWS*MAX_COLS)-1:0]    mem_addr_o,
  output logic                                    sim_we_o,
  output logic [15:0]                             sim_wdata_o,
  input  logic [15:0]                             sim_rdata_i,
  output logic                                    score_we_o,
  output logic [SCORE_BITS-1:0]                   score_wdata_o,
  input  logic [SCORE_BITS-1:0]                   score_rdata_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [4:0]                              out_row_o,
  output logic [4:0]                              out_col_o,
  output logic [23:0]                             out_best_o,
  output logic                                    out_end_o
);
  import msp_pkg::*;

  localparam int unsigned RW   = $clog2(MAX_ROWS);
  localparam int unsigned CW   = $clog2(MAX_COLS);
  localparam int unsigned NRW  = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW  = $clog2(MAX_COLS + 1);
  localparam int unsigned AW   = $clog2(MAX_ROWS * MAX_COLS);
  localparam int unsigned TW   = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int unsigned SPAN = $clog2((MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS);
  localparam int unsigned PW   = 16 + SPAN;
  localparam int unsigned W    = ((SCORE_BITS > PW) ? SCORE_BITS : PW) + 2;

  localparam logic signed [W-1:0] SMAX = W'((64'sd1 <<< (SCORE_BITS - 1)) - 64'sd1);
  localparam logic signed [W-1:0] SMIN = -SMAX - W'(1);
  localparam logic signed [W-1:0] OMAX = W'(64'sd8388607);
  localparam logic signed [W-1:0] OMIN = W'(-64'sd8388608);

  // Configuration.
  logic [15:0] jp_q;
  logic [5:0]  rows_q, cols_q;
  logic [NRW-1:0] nr;
  logic [NCW-1:0] nc;
  logic [TW-1:0]  total;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      jp_q   <= JUMP_PENALTY_RST;
      rows_q <= ROWS_RST;
      cols_q <= COLS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_JUMP_PENALTY: jp_q   <= cfg_data_i;
        CFG_ROWS_IN_USE:  rows_q <= cfg_data_i[5:0];
        CFG_COLS_IN_USE:  cols_q <= cfg_data_i[5:0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    if (rows_q < 6'd2) nr = NRW'(2);
    else if (7'(rows_q) > 7'(MAX_ROWS)) nr = NRW'(MAX_ROWS);
    else nr = NRW'(rows_q);
    if (cols_q < 6'd2) nc = NCW'(2);
    else if (7'(cols_q) > 7'(MAX_COLS)) nc = NCW'(MAX_COLS);
    else nc = NCW'(cols_q);
    total = TW'(nr) * TW'(nc);
  end

  // Registers.
  logic [AW-1:0]                load_idx_q;
  logic signed [15:0]           in_sim_q;
  logic                         in_acc_q, in_last_q;
  logic                         phase_q;
  logic [RW-1:0]                cur_r_q, i_q, best_r_q;
  logic [CW-1:0]                cur_c_q, j_q, best_c_q;
  logic [PW-1:0]                pen_q;
  logic signed [W-1:0]          m_q;
  logic signed [SCORE_BITS-1:0] best_q, dn_q, rt_q, dg_q;
  logic                         out_valid_q, out_end_q;
  logic [4:0]                   out_row_q, out_col_q;
  logic [23:0]                  out_best_q;

  // Address generation: flat index r + c*R, one small multiply.
  logic [AW-1:0] kw;
  logic [RW-1:0] ar;
  logic [CW-1:0] ac;
  logic [AW-1:0] cell_addr;

  assign kw = (TW'(load_idx_q) >= total) ? '0 : load_idx_q;

  always_comb begin
    ar = cur_r_q;
    ac = cur_c_q;
    unique case (cmd_i.addr_sel)
      A_LOAD:  begin ar = cur_r_q;            ac = cur_c_q;            end
      A_CELL:  begin ar = cur_r_q;            ac = cur_c_q;            end
      A_ISCAN: begin ar = i_q;                ac = cur_c_q + CW'(1);   end
      A_JSCAN: begin ar = cur_r_q + RW'(1);   ac = j_q;                end
      A_DOWN:  begin ar = cur_r_q + RW'(1);   ac = cur_c_q;            end
      A_RIGHT: begin ar = cur_r_q;            ac = cur_c_q + CW'(1);   end
      A_DIAG:  begin ar = cur_r_q + RW'(1);   ac = cur_c_q + CW'(1);   end
      default: begin ar = cur_r_q;            ac = cur_c_q;            end
    endcase
  end

  assign cell_addr  = AW'(TW'(ar) + TW'(ac) * TW'(nr));
  assign mem_addr_o = (cmd_i.addr_sel == A_LOAD) ? kw : cell_addr;

  // Element load, with saturating accumulate.
  logic signed [16:0] acc_sum;
  logic signed [15:0] load_val;

  always_comb begin
    acc_sum = 17'(in_sim_q) + 17'($signed(sim_rdata_i));
    if (!in_acc_q) load_val = in_sim_q;
    else if (acc_sum[16] != acc_sum[15]) load_val = acc_sum[16] ? 16'sh8000 : 16'sh7FFF;
    else load_val = acc_sum[15:0];
  end

  // Penalized candidate and cell score.
  logic signed [W-1:0]          score_w, cand, sim_w, v_wide, best_w;
  logic signed [SCORE_BITS-1:0] v;
  logic [4:0]                   row5, col5;
  logic [23:0]                  best24;

  always_comb begin
    score_w = W'($signed(score_rdata_i));
    cand    = score_w - $signed(W'(pen_q));
    sim_w   = W'($signed(sim_rdata_i));
    v_wide  = m_q + sim_w;
    if (v_wide > SMAX) v = SMAX[SCORE_BITS-1:0];
    else if (v_wide < SMIN) v = SMIN[SCORE_BITS-1:0];
    else v = v_wide[SCORE_BITS-1:0];
    best_w = W'(best_q);
    if (best_w > OMAX) best24 = OMAX[23:0];
    else if (best_w < OMIN) best24 = OMIN[23:0];
    else best24 = best_w[23:0];
    row5 = 5'(cur_r_q);
    col5 = 5'(cur_c_q);
  end

  assign sim_we_o      = (cmd_i.op == OP_LOAD_WRITE);
  assign sim_wdata_o   = load_val;
  assign score_we_o    = (cmd_i.op == OP_COPY_WRITE) || (cmd_i.op == OP_CELL_WRITE);
  assign score_wdata_o = (cmd_i.op == OP_COPY_WRITE) ?
                         SCORE_BITS'($signed(sim_rdata_i)) : v;

  // Status.
  logic at_edge;
  assign at_edge = (NRW'(cur_r_q) == nr - NRW'(1)) || (NCW'(cur_c_q) == nc - NCW'(1));

  always_comb begin
    stat_o.last      = in_last_q;
    stat_o.copy_last = phase_q && (NRW'(cur_r_q) == nr - NRW'(1));
    stat_o.i_done    = ((NRW + 1)'(i_q) + (NRW + 1)'(2)) > (NRW + 1)'(nr);
    stat_o.j_done    = ((NCW + 1)'(j_q) + (NCW + 1)'(2)) > (NCW + 1)'(nc);
    stat_o.cell_last = (cur_r_q == '0) && (cur_c_q == '0);
    stat_o.at_edge   = at_edge;
    stat_o.out_free  = !out_valid_q || out_ready_i;
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      load_idx_q  <= '0;
      best_q      <= SCORE_BITS'(BEST_INIT);
      best_r_q    <= '0;
      best_c_q    <= '0;
      out_valid_q <= 1'b0;
      in_last_q   <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      if (out_ready_i && cmd_i.op != OP_EMIT && cmd_i.op != OP_EMIT_END) begin
        out_valid_q <= 1'b0;
      end
      unique case (cmd_i.op)
        OP_LOAD_TAKE: begin
          load_idx_q <= kw;
          in_last_q  <= in_last_i;
        end
        OP_LOAD_WRITE: begin
          if (in_last_q || (TW'(load_idx_q) + TW'(1) >= total)) load_idx_q <= '0;
          else load_idx_q <= load_idx_q + AW'(1);
        end
        OP_COPY_INIT:  phase_q <= 1'b0;
        OP_COPY_WRITE: if (!phase_q && NCW'(cur_c_q) == nc - NCW'(1)) phase_q <= 1'b1;
        OP_SCORE_INIT: best_q <= SCORE_BITS'(BEST_INIT);
        OP_CELL_WRITE: begin
          if (v > best_q) begin
            best_q   <= v;
            best_r_q <= cur_r_q;
            best_c_q <= cur_c_q;
          end
        end
        OP_EMIT, OP_EMIT_END: out_valid_q <= 1'b1;
        default: ;
      endcase
    end
  end

  // Payload and counters.
  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_LOAD_TAKE: begin
        in_sim_q <= $signed(in_sim_i);
        in_acc_q <= in_acc_i;
      end
      OP_COPY_INIT: begin
        cur_r_q <= RW'(nr - NRW'(1));
        cur_c_q <= '0;
      end
      OP_COPY_WRITE: begin
        if (!phase_q) begin
          if (NCW'(cur_c_q) == nc - NCW'(1)) cur_r_q <= '0;
          else cur_c_q <= cur_c_q + CW'(1);
        end else begin
          cur_r_q <= cur_r_q + RW'(1);
        end
      end
      OP_SCORE_INIT: begin
        cur_r_q <= RW'(nr - NRW'(2));
        cur_c_q <= CW'(nc - NCW'(2));
      end
      OP_CELL_INIT: begin
        m_q   <= W'(START_FLOOR);
        pen_q <= PW'(jp_q);
        i_q   <= cur_r_q + RW'(1);
      end
      OP_ISCAN_USE, OP_JSCAN_USE: begin
        if (cand > m_q) m_q <= cand;
        pen_q <= pen_q + PW'(jp_q);
        if (cmd_i.op == OP_ISCAN_USE) i_q <= i_q + RW'(1);
        else j_q <= j_q + CW'(1);
      end
      OP_JSCAN_INIT: begin
        pen_q <= PW'(jp_q);
        j_q   <= cur_c_q + CW'(1);
      end
      OP_CELL_WRITE: begin
        if (cur_r_q == '0) begin
          if (cur_c_q != '0) begin
            cur_c_q <= cur_c_q - CW'(1);
            cur_r_q <= RW'(nr - NRW'(2));
          end
        end else begin
          cur_r_q <= cur_r_q - RW'(1);
        end
      end
      OP_PATH_INIT: begin
        cur_r_q <= (NRW'(best_r_q) > nr - NRW'(1)) ? RW'(nr - NRW'(1)) : best_r_q;
        cur_c_q <= (NCW'(best_c_q) > nc - NCW'(1)) ? CW'(nc - NCW'(1)) : best_c_q;
      end
      OP_TAKE_DN: dn_q <= $signed(score_rdata_i);
      OP_TAKE_RT: rt_q <= $signed(score_rdata_i);
      OP_TAKE_DG: dg_q <= $signed(score_rdata_i);
      OP_EMIT: begin
        out_row_q  <= row5;
        out_col_q  <= col5;
        out_best_q <= best24;
        out_end_q  <= 1'b0;
        if (dn_q > rt_q && dn_q > dg_q) begin
          cur_r_q <= cur_r_q + RW'(1);
        end else if (rt_q > dg_q) begin
          cur_c_q <= cur_c_q + CW'(1);
        end else begin
          cur_r_q <= cur_r_q + RW'(1);
          cur_c_q <= cur_c_q + CW'(1);
        end
      end
      OP_EMIT_END: begin
        out_row_q  <= row5;
        out_col_q  <= col5;
        out_best_q <= best24;
        out_end_q  <= 1'b1;
      end
      default: ;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_row_o   = out_row_q;
  assign out_col_o   = out_col_q;
  assign out_best_o  = out_best_q;
  assign out_end_o   = out_end_q;

  a_one_store_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(sim_we_o && score_we_o))
    else $error("both stores written in one cycle");

  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT) |-> ((NRW'(cur_r_q) < nr - NRW'(1)) &&
                                (NCW'(cur_c_q) < nc - NCW'(1))))
    else $error("path point outside the interior");

  a_end_on_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_EMIT_END) |-> at_edge)
    else $error("final path point not on an edge");

endmodule

>>> design/max_score_path_dp_top.sv
// ----------------------------------------------------------------------------
// max_score_path_dp_top: best-scoring path through a similarity matrix
// Loads a matrix element by element, scores it with a jump penalty and
// streams the greedy path from the best cell.
// ----------------------------------------------------------------------------
// Each loaded element is read (for accumulate) and then written. An element
// with tlast starts a pass: the edge copy, then every interior cell scans the
// column to its right and the row below it one score at a time, since every
// neighbor score comes through the one read port of the score memory. Each
// path point reads its three neighbor scores and may wait on m_axis_tready.
// No input is taken until the final path point has been handed to the output
// register; the stores need no clearing after reset.
module max_score_path_dp_top #(
  parameter int unsigned MAX_ROWS   = 32,
  parameter int unsigned MAX_COLS   = 32,
  parameter int unsigned SCORE_BITS = 24
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid,
  output logic                                  s_axis_tready,
  input  logic [15:0]                           s_axis_tdata,   // [15:0] sim_value
  input  logic                                  s_axis_tuser,   // [0] accumulate
  input  logic                                  s_axis_tlast,
  output logic                                  m_axis_tvalid,
  input  logic                                  m_axis_tready,
  // [4:0] path_row, [9:5] path_col, [33:10] best_score, [39:34] zero
  output logic [39:0]                           m_axis_tdata,
  output logic                                  m_axis_tlast,
  input  logic                                  cfg_we_i,
  input  logic [msp_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [msp_pkg::CFG_DATA_W-1:0]        cfg_data_i
);
  import msp_pkg::*;

  localparam int unsigned DEPTH = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = $clog2(DEPTH);

  msp_cmd_t  cmd;
  msp_stat_t stat;

  logic [AW-1:0]         mem_addr;
  logic                  sim_we, score_we;
  logic [15:0]           sim_wdata, sim_rdata;
  logic [SCORE_BITS-1:0] score_wdata, score_rdata;
  logic [4:0]            out_row, out_col;
  logic [23:0]           out_best;

  msp_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .stat_i          (stat),
    .cmd_o           (cmd)
  );

  msp_dp #(
    .MAX_ROWS   (MAX_ROWS),
    .MAX_COLS   (MAX_COLS),
    .SCORE_BITS (SCORE_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .in_sim_i      (s_axis_tdata),
    .in_acc_i      (s_axis_tuser),
    .in_last_i     (s_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .mem_addr_o    (mem_addr),
    .sim_we_o      (sim_we),
    .sim_wdata_o   (sim_wdata),
    .sim_rdata_i   (sim_rdata),
    .score_we_o    (score_we),
    .score_wdata_o (score_wdata),
    .score_rdata_i (score_rdata),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_row_o     (out_row),
    .out_col_o     (out_col),
    .out_best_o    (out_best),
    .out_end_o     (m_axis_tlast)
  );

  msp_ram #(
    .WIDTH (16),
    .DEPTH (DEPTH)
  ) u_sim_ram (
    .clk_i   (clk_i),
    .we_i    (sim_we),
    .waddr_i (mem_addr),
    .wdata_i (sim_wdata),
    .raddr_i (mem_addr),
    .rdata_o (sim_rdata)
  );

  msp_ram #(
    .WIDTH (SCORE_BITS),
    .DEPTH (DEPTH)
  ) u_score_ram (
    .clk_i   (clk_i),
    .we_i    (score_we),
    .waddr_i (mem_addr),
    .wdata_i (score_wdata),
    .raddr_i (mem_addr),
    .rdata_o (score_rdata)
  );

  assign m_axis_tdata = {6'd0, out_best, out_col, out_row};

endmodule

>>> dv/tb_max_score_path_dp_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_max_score_path_dp_top: self-checking bench for the max score path block
// Loads similarity matrices of many sizes, predicts the scored matrix and the
// greedy path in a scoreboard class, and compares every path point that the
// block streams out, under several patterns of sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb_max_score_path_dp_top;
  import msp_pkg::*;

  localparam int CELL_COUNT = 1024;
  localparam int CYCLE_LIMIT = 3000000;
  localparam int DRAIN_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 4000;

  typedef struct packed {
    logic [4:0]         row;
    logic [4:0]         col;
    logic signed [23:0] score;
    logic               fin;
  } path_point_t;

  class path_predictor;
    int unsigned penalty = 256;
    int unsigned rows_cfg = 32;
    int unsigned cols_cfg = 32;
    int          sim_mem[CELL_COUNT];
    longint      score_mem[CELL_COUNT];
    int unsigned load_idx;
    longint      best_val = BEST_INIT;
    int unsigned best_r;
    int unsigned best_c;
    path_point_t pending_points[$];
    int          mismatches;

    function int unsigned fit_size(int unsigned v);
      if (v < 2) return 2;
      if (v > 32) return 32;
      return v;
    endfunction

    function longint sat(longint v, int bits);
      longint hi;
      hi = (longint'(1) <<< (bits - 1)) - 1;
      if (v > hi) return hi;
      if (v < -hi - 1) return -hi - 1;
      return v;
    endfunction

    function void set_reg(logic [1:0] idx, logic [15:0] val);
      case (idx)
        CFG_JUMP_PENALTY: penalty = val;
        CFG_ROWS_IN_USE: rows_cfg = val[5:0];
        CFG_COLS_IN_USE: cols_cfg = val[5:0];
        default: ;
      endcase
    endfunction

    function int unsigned slot();
      int unsigned total;
      total = fit_size(rows_cfg) * fit_size(cols_cfg);
      return (load_idx >= total) ? 0 : load_idx;
    endfunction

    function void score_matrix(int unsigned nr, int unsigned nc);
      longint m, v;
      for (int c = 0; c < nc; c++) score_mem[nr - 1 + c * nr] = sim_mem[nr - 1 + c * nr];
      for (int r = 0; r < nr; r++) score_mem[r + (nc - 1) * nr] = sim_mem[r + (nc - 1) * nr];
      best_val = BEST_INIT;
      for (int c = nc - 2; c >= 0; c--) begin
        for (int r = nr - 2; r >= 0; r--) begin
          m = START_FLOOR;
          for (int i = r + 1; i < nr - 1; i++) begin
            v = score_mem[(c + 1) * nr + i] - longint'(penalty) * (i - r);
            if (v > m) m = v;
          end
          for (int j = c + 1; j < nc - 1; j++) begin
            v = score_mem[r + 1 + nr * j] - longint'(penalty) * (j - c);
            if (v > m) m = v;
          end
          v = sat(m + sim_mem[r + c * nr], 24);
          score_mem[r + c * nr] = v;
          if (v > best_val) begin
            best_val = v;
            best_r = r;
            best_c = c;
          end
        end
      end
    endfunction

    function void note_input(logic signed [15:0] sim, logic acc, logic fin);
      int unsigned nr, nc, k, r, c;
      longint s, dn, rt, dg;
      path_point_t p;
      nr = fit_size(rows_cfg);
      nc = fit_size(cols_cfg);
      k = slot();
      s = sim;
      if (acc) s = sat(s + sim_mem[k], 16);
      sim_mem[k] = int'(s);
      load_idx = k + 1;
      if (load_idx >= nr * nc) load_idx = 0;
      if (!fin) return;
      load_idx = 0;
      score_matrix(nr, nc);
      r = (best_r > nr - 1) ? nr - 1 : best_r;
      c = (best_c > nc - 1) ? nc - 1 : best_c;
      p.score = 24'(best_val);
      while (r != nr - 1 && c != nc - 1) begin
        dn = score_mem[r + 1 + c * nr];
        rt = score_mem[r + (c + 1) * nr];
        dg = score_mem[r + 1 + (c + 1) * nr];
        p.row = 5'(r);
        p.col = 5'(c);
        p.fin = 1'b0;
        pending_points = {pending_points, p};
        if (dn > rt && dn > dg) r++;
        else if (rt > dg) c++;
        else begin
          r++;
          c++;
        end
      end
      p.row = 5'(r);
      p.col = 5'(c);
      p.fin = 1'b1;
      pending_points = {pending_points, p};
    endfunction

    function void check_result(logic [39:0] data, logic fin);
      path_point_t e;
      if (pending_points.size() == 0) begin
        $error("unexpected path point row=%0d col=%0d", data[4:0], data[9:5]);
        mismatches++;
        return;
      end
      e = pending_points.pop_front();
      if (data[4:0] !== e.row) begin
        $error("path_row: expected %0d, got %0d", e.row, data[4:0]);
        mismatches++;
      end
      if (data[9:5] !== e.col) begin
        $error("path_col: expected %0d, got %0d", e.col, data[9:5]);
        mismatches++;
      end
      if (data[33:10] !== e.score) begin
        $error("best_score: expected %0d, got %0d", e.score, $signed(data[33:10]));
        mismatches++;
      end
      if (fin !== e.fin) begin
        $error("path_end: expected %0b, got %0b", e.fin, fin);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  path_predictor pred = new();
  bit          loaded[CELL_COUNT];
  int          idle_mode;      // 0 none, 1 sender, 2 receiver, 3 both
  bit          long_hold = 1'b0;
  event        hold_req;
  int          items_sent;
  int          cycle_count = 0;

  max_score_path_dp_top DUT (.*);

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // The long receiver hold-off is counted here, so the block fills up while
  // the sender keeps offering items.
  always begin
    @(hold_req);
    @(posedge clk_i);
    long_hold = 1'b1;
    repeat (LONG_HOLD_CYCLES) @(posedge clk_i);
    long_hold = 1'b0;
  end

  always @(negedge clk_i) begin
    if (long_hold) begin
      m_axis_tready <= 1'b0;
    end else if (idle_mode >= 2) begin
      m_axis_tready <= ($urandom_range(99) >= (idle_mode == 2 ? 51 : 8));
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) pred.check_result(m_axis_tdata, m_axis_tlast);
  end

  task automatic write_reg(logic [1:0] idx, logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    pred.set_reg(idx, val);
  endtask

  task automatic send_item(logic [15:0] sim, logic acc, logic fin);
    int pct;
    pct = (idle_mode == 1) ? 51 : (idle_mode == 3 ? 8 : 0);
    @(negedge clk_i);
    while ($urandom_range(99) < pct) begin
      s_axis_tvalid = 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata = sim;
    s_axis_tuser = acc;
    s_axis_tlast = fin;
    do @(posedge clk_i); while (!s_axis_tready);
    pred.note_input(sim, acc, fin);
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (pred.pending_points.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  // Sends n_items elements; last is only sent once every cell in use
  // holds a written value, and accumulate only onto written cells.
  task automatic run_matrix(int style, int n_items);
    int unsigned total, k;
    logic [15:0] sim;
    logic        acc, fin;
    bit          full;
    total = pred.fit_size(pred.rows_cfg) * pred.fit_size(pred.cols_cfg);
    for (int n = 0; n < n_items; n++) begin
      k = pred.slot();
      case (style)
        0: begin
          case ($urandom_range(4))
            0: sim = 16'h7fff;
            1: sim = 16'h8000;
            2: sim = 16'h0000;
            3: sim = 16'hffff;
            default: sim = 16'h0001;
          endcase
        end
        1: sim = 16'h8000;
        default: sim = $urandom_range(3) == 0 ? 16'($urandom) :
                                                16'($signed($urandom_range(1600)) - 800);
      endcase
      acc = loaded[k] && $urandom_range(3) == 0;
      full = 1'b1;
      for (int i = 0; i < total; i++) if (!loaded[i] && i != k) full = 1'b0;
      fin = full && (n == n_items - 1 || $urandom_range(15) == 0);
      send_item(sim, acc, fin);
      loaded[k] = 1'b1;
    end
  endtask

  initial begin
    int unsigned nr, nc;
    int          phase;
    idle_mode = 0;
    items_sent = 0;
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: extreme values on a 2 by 2 matrix, then a matrix whose
    // interior never beats the best-value seed.
    write_reg(CFG_JUMP_PENALTY, 16'd0);
    write_reg(CFG_ROWS_IN_USE, 16'd1);
    write_reg(CFG_COLS_IN_USE, 16'd0);
    run_matrix(0, 10);
    wait_idle();
    write_reg(CFG_JUMP_PENALTY, 16'hffff);
    write_reg(CFG_ROWS_IN_USE, 16'd3);
    write_reg(CFG_COLS_IN_USE, 16'd3);
    run_matrix(1, 9);
    wait_idle();

    phase = 0;
    while (items_sent < 200 || phase < 8) begin
      idle_mode = phase % 4;
      case (phase)
        0: begin nr = 63; nc = 2; end
        1: begin nr = 2; nc = 40; end
        2: begin nr = 32; nc = 3; end
        default: begin
          nr = $urandom_range(2, 7);
          nc = $urandom_range(2, 7);
          if ($urandom_range(7) == 0) nr = $urandom_range(63);
          else if ($urandom_range(7) == 0) nc = $urandom_range(63);
          if (nr > 8 && nc > 3) nc = 3;
          if (nc > 8 && nr > 3) nr = 3;
        end
      endcase
      write_reg(CFG_JUMP_PENALTY, phase == 1 ? 16'hffff : 16'($urandom_range(700)));
      write_reg(CFG_ROWS_IN_USE, 16'(nr));
      write_reg(CFG_COLS_IN_USE, 16'(nc));
      if (phase == 1) -> hold_req;
      run_matrix(2, pred.fit_size(nr) * pred.fit_size(nc) + $urandom_range(6));
      // Occasionally send a few more elements; the matrix is already full, so
      // the last of them carries last and starts another pass. During the long
      // hold-off these items keep the sender busy against a full block.
      if (phase == 1 || $urandom_range(3) == 0) run_matrix(2, $urandom_range(1, 4));
      wait_idle();
      phase++;
    end

    if (pred.mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule
